### rtl/tree_path_intersection_lca_macros.svh
// Assertion macros shared by the path intersection block.
// Depends on a clock named clk and a synchronous reset named rst in the including scope.
`ifndef TREE_PATH_INTERSECTION_LCA_MACROS_SVH
`define TREE_PATH_INTERSECTION_LCA_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define TPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define TPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tpl_pkg.sv
// Package for the tree path intersection block: field widths, microcode types,
// microcode addresses and the microprogram itself. No dependencies.
`default_nettype none

package tpl_pkg;

  // Field widths fixed by the item format.
  localparam int ID_W  = 12;
  localparam int DEP_W = 12;
  localparam int UPC_W = 5;

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [DEP_W-1:0] dep_t;
  typedef logic [UPC_W-1:0] upc_t;

  // Sequencer state.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  // Datapath micro-operations.
  typedef enum logic [4:0] {
    U_NOP,
    U_Q_AB,
    U_SAVE_E_CD,
    U_SAVE_F_RD_E,
    U_CAP_DE_RD_F,
    U_CMP_EF,
    U_SET_1,
    U_CHK_1,
    U_CHK_2,
    U_LD_RD_P,
    U_LD_WR_ROOT,
    U_LD_RD_UP,
    U_LD_WR_LVL,
    U_RD_DEP_X,
    U_CAP_DX_RD_Y,
    U_CAP_DY_SWAP,
    U_RD_ANC_X,
    U_CAP_UP_RD_DEP,
    U_STEP1,
    U_CAP_UP_RD_ANC_Y,
    U_STEP2,
    U_RD_ANC_X0,
    U_CAP_R_ANC,
    U_CAP_R_X
  } uop_t;

  // Sequencing conditions.
  typedef enum logic [3:0] {
    C_NEXT,
    C_JUMP,
    C_CALL,
    C_RET,
    C_LVL_NZ,
    C_LVL_LAST,
    C_X_EQ_Y,
    C_END,
    C_END_OUT
  } cond_t;

  // Level counter operations.
  typedef enum logic [2:0] {
    L_HOLD,
    L_TOP,
    L_DEC,
    L_ZERO,
    L_INC
  } lvl_op_t;

  // One control word of the microprogram.
  typedef struct packed {
    uop_t    uop;
    cond_t   cond;
    lvl_op_t lvl_op;
    upc_t    target;
  } ctl_word_t;

  // Microcode addresses.
  localparam upc_t UA_Q_START  = 5'd0;
  localparam upc_t UA_Q_M1     = 5'd1;
  localparam upc_t UA_Q_M2     = 5'd2;
  localparam upc_t UA_Q_M3     = 5'd3;
  localparam upc_t UA_Q_M4     = 5'd4;
  localparam upc_t UA_Q_M5     = 5'd5;
  localparam upc_t UA_Q_M6     = 5'd6;
  localparam upc_t UA_Q_M7     = 5'd7;
  localparam upc_t UA_LD_START = 5'd8;
  localparam upc_t UA_LD_ROOT  = 5'd9;
  localparam upc_t UA_LD_LOOP  = 5'd10;
  localparam upc_t UA_LD_WRITE = 5'd11;
  localparam upc_t UA_LCA      = 5'd12;
  localparam upc_t UA_LCA_DY   = 5'd13;
  localparam upc_t UA_LCA_SWAP = 5'd14;
  localparam upc_t UA_LIFT     = 5'd15;
  localparam upc_t UA_LIFT_DEP = 5'd16;
  localparam upc_t UA_LIFT_CMP = 5'd17;
  localparam upc_t UA_LCA_EQ   = 5'd18;
  localparam upc_t UA_CLIMB    = 5'd19;
  localparam upc_t UA_CLIMB_Y  = 5'd20;
  localparam upc_t UA_CLIMB_CMP = 5'd21;
  localparam upc_t UA_LCA_PAR  = 5'd22;
  localparam upc_t UA_LCA_RET  = 5'd23;
  localparam upc_t UA_HIT      = 5'd24;
  localparam upc_t UA_LD_END   = 5'd25;

  function automatic ctl_word_t cw(uop_t u, cond_t c, lvl_op_t l, upc_t t);
    ctl_word_t w;
    w.uop    = u;
    w.cond   = c;
    w.lvl_op = l;
    w.target = t;
    return w;
  endfunction

  // The microprogram: query main line, load line and the shared LCA subroutine.
  function automatic ctl_word_t ucode(upc_t a);
    ctl_word_t w;
    case (a)
      UA_Q_START:   w = cw(U_Q_AB,            C_CALL,     L_HOLD, UA_LCA);
      UA_Q_M1:      w = cw(U_SAVE_E_CD,       C_CALL,     L_HOLD, UA_LCA);
      UA_Q_M2:      w = cw(U_SAVE_F_RD_E,     C_NEXT,     L_HOLD, UA_Q_START);
      UA_Q_M3:      w = cw(U_CAP_DE_RD_F,     C_NEXT,     L_HOLD, UA_Q_START);
      UA_Q_M4:      w = cw(U_CMP_EF,          C_NEXT,     L_HOLD, UA_Q_START);
      UA_Q_M5:      w = cw(U_SET_1,           C_CALL,     L_HOLD, UA_LCA);
      UA_Q_M6:      w = cw(U_CHK_1,           C_CALL,     L_HOLD, UA_LCA);
      UA_Q_M7:      w = cw(U_CHK_2,           C_END_OUT,  L_HOLD, UA_Q_START);
      UA_LD_START:  w = cw(U_LD_RD_P,         C_NEXT,     L_HOLD, UA_Q_START);
      UA_LD_ROOT:   w = cw(U_LD_WR_ROOT,      C_NEXT,     L_ZERO, UA_Q_START);
      UA_LD_LOOP:   w = cw(U_LD_RD_UP,        C_LVL_LAST, L_HOLD, UA_LD_END);
      UA_LD_WRITE:  w = cw(U_LD_WR_LVL,       C_JUMP,     L_INC,  UA_LD_LOOP);
      UA_LCA:       w = cw(U_RD_DEP_X,        C_NEXT,     L_HOLD, UA_Q_START);
      UA_LCA_DY:    w = cw(U_CAP_DX_RD_Y,     C_NEXT,     L_HOLD, UA_Q_START);
      UA_LCA_SWAP:  w = cw(U_CAP_DY_SWAP,     C_NEXT,     L_TOP,  UA_Q_START);
      UA_LIFT:      w = cw(U_RD_ANC_X,        C_NEXT,     L_HOLD, UA_Q_START);
      UA_LIFT_DEP:  w = cw(U_CAP_UP_RD_DEP,   C_NEXT,     L_HOLD, UA_Q_START);
      UA_LIFT_CMP:  w = cw(U_STEP1,           C_LVL_NZ,   L_DEC,  UA_LIFT);
      UA_LCA_EQ:    w = cw(U_NOP,             C_X_EQ_Y,   L_TOP,  UA_HIT);
      UA_CLIMB:     w = cw(U_RD_ANC_X,        C_NEXT,     L_HOLD, UA_Q_START);
      UA_CLIMB_Y:   w = cw(U_CAP_UP_RD_ANC_Y, C_NEXT,     L_HOLD, UA_Q_START);
      UA_CLIMB_CMP: w = cw(U_STEP2,           C_LVL_NZ,   L_DEC,  UA_CLIMB);
      UA_LCA_PAR:   w = cw(U_RD_ANC_X0,       C_NEXT,     L_HOLD, UA_Q_START);
      UA_LCA_RET:   w = cw(U_CAP_R_ANC,       C_RET,      L_HOLD, UA_Q_START);
      UA_HIT:       w = cw(U_CAP_R_X,         C_RET,      L_HOLD, UA_Q_START);
      UA_LD_END:    w = cw(U_NOP,             C_END,      L_HOLD, UA_Q_START);
      default:      w = cw(U_NOP,             C_END,      L_HOLD, UA_Q_START);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/tpl_in_if.sv
// Input channel of the path intersection block: handshake and item fields.
// Depends on tpl_pkg for the field widths.
`default_nettype none

interface tpl_in_if;
  import tpl_pkg::*;

  logic valid;
  logic ready;
  logic kind;
  id_t  node_id;
  id_t  parent_id;
  id_t  first_a;
  id_t  first_b;
  id_t  second_c;
  id_t  second_d;

  modport source (
    output valid, kind, node_id, parent_id, first_a, first_b, second_c, second_d,
    input  ready
  );

  modport sink (
    input  valid, kind, node_id, parent_id, first_a, first_b, second_c, second_d,
    output ready
  );
endinterface

`default_nettype wire

### rtl/tpl_out_if.sv
// Result channel of the path intersection block: handshake and result field.
// No dependencies.
`default_nettype none

interface tpl_out_if;
  logic valid;
  logic ready;
  logic paths_meet;

  modport source (
    output valid, paths_meet,
    input  ready
  );

  modport sink (
    input  valid, paths_meet,
    output ready
  );
endinterface

`default_nettype wire

### rtl/tree_path_intersection_lca.sv
// Tree path intersection block. A load beat (kind 0) adds a node below its parent
// (parent 0 makes it a root); parents must be loaded before children, and loads with
// node 0 or an id of NODES or more are dropped. A query beat (kind 1) names paths a-b
// and c-d and returns one beat, paths_meet, set when the paths share a node; endpoints
// of NODES or more count as node 0. Items are taken one at a time. A query finishes
// sooner when the endpoints of a path lie on one branch. Its running time is set by the
// single read port of the ancestor table: each lowest-common-ancestor search is a
// subroutine of the microcoded sequencer that steps through the jump levels in each of
// its two lifting walks, and a query calls it four times. A finished result sits in an
// output register, so the next item is taken while it waits.
// No clearing pass is needed after reset: node 0 reads as zero by address decode.
// Depends on tpl_pkg, tpl_in_if, tpl_out_if, tpl_ram and the assertion macro header.
`default_nettype none
`include "tree_path_intersection_lca_macros.svh"

module tree_path_intersection_lca #(
  parameter int NODES  = 4096,
  parameter int LEVELS = 12
) (
  input wire logic  clk,
  input wire logic  rst,
  tpl_in_if.sink    req,
  tpl_out_if.source rsp
);
  import tpl_pkg::*;

  localparam int AW        = $clog2(NODES);
  localparam int LW        = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ANC_DEPTH = NODES * (2 ** LW);

  // Sequencer registers.
  seq_state_t state, state_next;
  upc_t       upc, upc_next;
  upc_t       ret, ret_next;
  ctl_word_t  ctl;

  // Datapath registers.
  id_t           qa, qb, qc, qd;
  id_t           e, f, x, y, up, r;
  dep_t          dx, dy;
  logic [LW-1:0] lvl;
  logic          ge;
  logic          meet;

  // Output register.
  logic out_vld;
  logic out_meet;
  logic out_free;
  logic push;

  // Memory ports.
  logic              dep_we;
  logic [AW-1:0]     dep_waddr;
  dep_t              dep_wdata;
  logic [AW-1:0]     dep_raddr;
  dep_t              dep_rdata;
  logic              dep_zero;
  dep_t              dep_rd;
  logic              anc_we;
  logic [AW-1:0]     anc_wnode;
  logic [LW-1:0]     anc_wlvl;
  id_t               anc_wdata;
  logic [AW-1:0]     anc_rnode;
  logic [LW-1:0]     anc_rlvl;
  id_t               anc_rdata;
  logic              anc_zero;
  id_t               anc_rd;

  // Accept side and input decode.
  logic accept;
  id_t  ca, cb, cc, cd;
  logic load_ok;
  id_t  tgt;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;

  // Query endpoints beyond the table fall back to node 0.
  assign ca = (32'(req.first_a)  < NODES) ? req.first_a  : '0;
  assign cb = (32'(req.first_b)  < NODES) ? req.first_b  : '0;
  assign cc = (32'(req.second_c) < NODES) ? req.second_c : '0;
  assign cd = (32'(req.second_d) < NODES) ? req.second_d : '0;

  assign load_ok = (req.node_id != '0) && (32'(req.node_id) < NODES)
                   && (32'(req.parent_id) < NODES);

  // The deeper of the two path apexes is the one tested against the other path.
  assign tgt = ge ? e : f;

  assign ctl      = ucode(upc);
  assign out_free = !out_vld || rsp.ready;

  // Node 0 is the all-zero sentinel; its entries are never written.
  assign dep_rd = dep_zero ? '0 : dep_rdata;
  assign anc_rd = anc_zero ? '0 : anc_rdata;

  // Memory address and write control decoded from the micro-operation.
  always_comb begin
    dep_raddr = AW'(x);
    anc_rnode = AW'(x);
    anc_rlvl  = lvl;
    dep_we    = 1'b0;
    dep_waddr = AW'(qa);
    dep_wdata = DEP_W'(dep_rd + 1'b1);
    anc_we    = 1'b0;
    anc_wnode = AW'(qa);
    anc_wlvl  = '0;
    anc_wdata = qb;
    if (state == ST_RUN) begin
      case (ctl.uop)
        U_SAVE_F_RD_E:     dep_raddr = AW'(e);
        U_CAP_DE_RD_F:     dep_raddr = AW'(f);
        U_LD_RD_P:         dep_raddr = AW'(qb);
        U_RD_DEP_X:        dep_raddr = AW'(x);
        U_CAP_DX_RD_Y:     dep_raddr = AW'(y);
        U_CAP_UP_RD_DEP:   dep_raddr = AW'(anc_rd);
        U_RD_ANC_X:        anc_rnode = AW'(x);
        U_CAP_UP_RD_ANC_Y: anc_rnode = AW'(y);
        U_RD_ANC_X0: begin
          anc_rnode = AW'(x);
          anc_rlvl  = '0;
        end
        U_LD_RD_UP:        anc_rnode = AW'(up);
        U_LD_WR_ROOT: begin
          dep_we = 1'b1;
          anc_we = 1'b1;
        end
        U_LD_WR_LVL: begin
          anc_we    = 1'b1;
          anc_wlvl  = LW'(lvl + 1'b1);
          anc_wdata = anc_rd;
        end
        default: begin
          dep_raddr = AW'(x);
        end
      endcase
    end
  end

  // Depth table, one row per node.
  tpl_ram #(
    .WIDTH (DEP_W),
    .DEPTH (NODES)
  ) u_depth_ram (
    .clk   (clk),
    .we    (dep_we),
    .waddr (dep_waddr),
    .wdata (dep_wdata),
    .raddr (dep_raddr),
    .rdata (dep_rdata)
  );

  // Ancestor table, addressed by node and jump level.
  tpl_ram #(
    .WIDTH (ID_W),
    .DEPTH (ANC_DEPTH)
  ) u_anc_ram (
    .clk   (clk),
    .we    (anc_we),
    .waddr ({anc_wnode, anc_wlvl}),
    .wdata (anc_wdata),
    .raddr ({anc_rnode, anc_rlvl}),
    .rdata (anc_rdata)
  );

  // Sentinel flags travel with the registered read data.
  always_ff @(posedge clk) begin
    dep_zero <= (dep_raddr == '0);
    anc_zero <= (anc_rnode == '0);
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      upc   <= UA_Q_START;
      ret   <= UA_Q_START;
    end else begin
      state <= state_next;
      upc   <= upc_next;
      ret   <= ret_next;
    end
  end

  // Next step, call and return, and the result push.
  always_comb begin
    state_next = state;
    upc_next   = upc;
    ret_next   = ret;
    push       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RUN;
          if (req.kind) begin
            upc_next = UA_Q_START;
          end else if (load_ok) begin
            upc_next = UA_LD_START;
          end else begin
            upc_next = UA_LD_END;
          end
        end
      end
      ST_RUN: begin
        upc_next = upc + 1'b1;
        case (ctl.cond)
          C_NEXT: upc_next = upc + 1'b1;
          C_JUMP: upc_next = ctl.target;
          C_CALL: begin
            ret_next = upc + 1'b1;
            upc_next = ctl.target;
          end
          C_RET: upc_next = ret;
          C_LVL_NZ: begin
            if (lvl != '0) begin
              upc_next = ctl.target;
            end
          end
          C_LVL_LAST: begin
            if (lvl == LW'(LEVELS - 1)) begin
              upc_next = ctl.target;
            end
          end
          C_X_EQ_Y: begin
            if (x == y) begin
              upc_next = ctl.target;
            end
          end
          C_END: state_next = ST_IDLE;
          C_END_OUT: begin
            upc_next = upc;
            if (out_free) begin
              push       = 1'b1;
              state_next = ST_IDLE;
            end
          end
          default: state_next = ST_IDLE;
        endcase
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers driven by the micro-operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (req.kind) begin
        qa <= ca;
        qb <= cb;
        qc <= cc;
        qd <= cd;
      end else begin
        qa <= req.node_id;
        qb <= req.parent_id;
      end
    end else if (state == ST_RUN) begin
      case (ctl.uop)
        U_Q_AB: begin
          x <= qa;
          y <= qb;
        end
        U_SAVE_E_CD: begin
          e <= r;
          x <= qc;
          y <= qd;
        end
        U_SAVE_F_RD_E: f <= r;
        U_CAP_DE_RD_F: dx <= dep_rd;
        U_CMP_EF:      ge <= (dx >= dep_rd);
        U_SET_1: begin
          x <= ge ? qc : qa;
          y <= tgt;
        end
        U_CHK_1: begin
          meet <= (r == tgt);
          x    <= ge ? qd : qb;
          y    <= tgt;
        end
        U_LD_WR_ROOT:  up <= qb;
        U_LD_WR_LVL:   up <= anc_rd;
        U_CAP_DX_RD_Y: dx <= dep_rd;
        U_CAP_DY_SWAP: begin
          if (dx < dep_rd) begin
            x  <= y;
            y  <= x;
            dy <= dx;
          end else begin
            dy <= dep_rd;
          end
        end
        U_CAP_UP_RD_DEP: up <= anc_rd;
        U_STEP1: begin
          if (dep_rd >= dy) begin
            x <= up;
          end
        end
        U_CAP_UP_RD_ANC_Y: up <= anc_rd;
        U_STEP2: begin
          if (up != anc_rd) begin
            x <= up;
            y <= anc_rd;
          end
        end
        U_CAP_R_ANC: r <= anc_rd;
        U_CAP_R_X:   r <= x;
        default: begin
          r <= r;
        end
      endcase
    end
  end

  // Level counter.
  always_ff @(posedge clk) begin
    if (state == ST_RUN) begin
      case (ctl.lvl_op)
        L_TOP:   lvl <= LW'(LEVELS - 1);
        L_DEC:   lvl <= lvl - 1'b1;
        L_ZERO:  lvl <= '0;
        L_INC:   lvl <= lvl + 1'b1;
        default: lvl <= lvl;
      endcase
    end
  end

  // Output register: one result beat per query.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (push) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_meet <= meet || (r == tgt);
    end
  end

  assign rsp.valid      = out_vld;
  assign rsp.paths_meet = out_meet;

  // A query beat starts the query line of the microprogram.
  `TPL_ASSERT_NXT(a_query_start, accept && req.kind,
    (state == ST_RUN) && (upc == UA_Q_START), "query did not start the query line")

  // A result is only raised from the final query step.
  `TPL_ASSERT_IMP(a_push_origin, $rose(out_vld),
    $past(state == ST_RUN) && $past(upc == UA_Q_M7), "result raised outside the query tail")

  // Inside the subroutine the return address points back into the query line.
  `TPL_ASSERT_IMP(a_ret_valid, (state == ST_RUN) && (upc >= UA_LCA) && (upc <= UA_HIT),
    (ret == UA_Q_M1) || (ret == UA_Q_M2) || (ret == UA_Q_M6) || (ret == UA_Q_M7),
    "subroutine entered with a bad return address")

  // Ancestor writes stay within the configured jump levels.
  `TPL_ASSERT_IMP(a_anc_wlvl, anc_we, 32'(anc_wlvl) < LEVELS,
    "ancestor write beyond the last jump level")

endmodule

`default_nettype wire

### rtl/tpl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tpl_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  wire logic                                clk,
  input  wire logic                                we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                    wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
